// ===== rtl/core/firewall_rule_table_match_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the firewall rule table match core
// Each macro expands to a concurrent assertion clocked on clk and disabled
// during rst; in synthesis the bodies are empty.
// ---------------------------------------------------------------------------
`ifndef FIREWALL_RULE_TABLE_MATCH_CORE_MACROS_SVH
`define FIREWALL_RULE_TABLE_MATCH_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define FRTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frtm assertion failed");
// Next-cycle implication
`define FRTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frtm assertion failed");
`else
`define FRTM_ASSERT_NOW(label, ante, cons)
`define FRTM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/frtm_pkg.sv =====
// ---------------------------------------------------------------------------
// frtm_pkg
// Shared types, codes and constants of the firewall rule table match core.
// ---------------------------------------------------------------------------
package frtm_pkg;

  // Table depth default, match reduction group width and queue depths
  localparam int MAX_RULES_DEF   = 64;
  localparam int GRP_W           = 32;
  localparam int OP_QUEUE_DEPTH  = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_ACCEPTED  = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  // Input item
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] addr_first;
    logic [31:0] addr_last;
    logic        addr_is_range;
    logic [15:0] port_first;
    logic [15:0] port_last;
    logic        port_is_range;
  } request_t;

  // Result item
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] match_position;
  } response_t;

  // One stored rule
  typedef struct packed {
    logic [31:0] addr_lo;
    logic [31:0] addr_hi;
    logic        addr_rng;
    logic [15:0] port_lo;
    logic [15:0] port_hi;
    logic        port_rng;
  } rule_t;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_ADD,
    OP_DELETE,
    OP_CHECK,
    OP_INVALID
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    rule_t    rule;
  } op_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REDUCE,
    BK_APPLY
  } bk_state_t;

endpackage

// ===== rtl/core/firewall_rule_table_match_core.sv =====
// The back-end sequencer finishes one item (parallel cell compare, grouped
// first-hit reduction, apply and shift) before it takes the next.
// Queues of 2 items on each side let front and back stall independently.
// Reset (rst, synchronous): empties both queues, clears every rule valid bit
// and idles the sequencer; rule contents are not cleared and need no pass.
// ---------------------------------------------------------------------------
// firewall_rule_table_match_core
// Ordered firewall rule table with add, delete and first-hit check commands.
// ---------------------------------------------------------------------------
`include "firewall_rule_table_match_core_macros.svh"

module firewall_rule_table_match_core #(
  parameter int MAX_RULES = frtm_pkg::MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  frtm_pkg::request_t  request,
  output logic                empty,
  input  logic                pop,
  output frtm_pkg::response_t response
);

  import frtm_pkg::*;

  logic                op_push;
  op_t                 op_in;
  logic                op_full;
  logic                op_pop;
  logic                op_empty;
  logic [$bits(op_t)-1:0] op_rdata;
  logic                res_push;
  response_t           res_item;
  logic                res_full;
  logic [$bits(response_t)-1:0] res_rdata;
  logic [MAX_RULES-1:0] valid_map;

  // Front: accept and classify
  frtm_front u_front (
    .request (request),
    .push    (push),
    .full    (full),
    .op_push (op_push),
    .op_item (op_in),
    .op_full (op_full)
  );

  // Operation queue
  frtm_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OP_QUEUE_DEPTH)
  ) u_op_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (op_push),
    .wdata (op_in),
    .full  (op_full),
    .pop   (op_pop),
    .rdata (op_rdata),
    .empty (op_empty)
  );

  // Back: rule table
  frtm_rule_table #(
    .MAX_RULES (MAX_RULES)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .op_empty  (op_empty),
    .op_item   (op_t'(op_rdata)),
    .op_pop    (op_pop),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full),
    .valid_map (valid_map)
  );

  // Result queue
  frtm_fifo #(
    .WIDTH ($bits(response_t)),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign response = response_t'(res_rdata);

  // Checks
  `FRTM_ASSERT_NOW(a_res_no_overflow, res_push, !res_full)
  `FRTM_ASSERT_NOW(a_op_no_underflow, op_pop, !op_empty)
  `FRTM_ASSERT_NOW(a_valid_packed, 1'b1, ((valid_map + 1'b1) & valid_map) == '0)
  `FRTM_ASSERT_NEXT(a_add_fills_head, res_push && (res_item.status == ST_ADDED), valid_map[0])

endmodule

// ===== rtl/core/frtm_fifo.sv =====
// ---------------------------------------------------------------------------
// frtm_fifo
// Small synchronous queue with push/full and pop/empty handshakes.
// ---------------------------------------------------------------------------
module frtm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/frtm_front.sv =====
// ---------------------------------------------------------------------------
// frtm_front
// Accepts command items, checks rule ranges and classifies each into an
// operation for the rule table.
// ---------------------------------------------------------------------------
module frtm_front (
  input  frtm_pkg::request_t request,
  input  logic               push,
  output logic               full,
  output logic               op_push,
  output frtm_pkg::op_t      op_item,
  input  logic               op_full
);

  import frtm_pkg::*;

  logic addr_ok;
  logic port_ok;
  logic rule_ok;

  // A range must run strictly upwards
  assign addr_ok = !request.addr_is_range || (request.addr_first < request.addr_last);
  assign port_ok = !request.port_is_range || (request.port_first < request.port_last);
  assign rule_ok = addr_ok && port_ok;

  assign full    = op_full;
  assign op_push = push && !op_full;

  // Classification
  always_comb begin
    op_item.rule.addr_lo  = request.addr_first;
    op_item.rule.addr_hi  = request.addr_last;
    op_item.rule.addr_rng = request.addr_is_range;
    op_item.rule.port_lo  = request.port_first;
    op_item.rule.port_hi  = request.port_last;
    op_item.rule.port_rng = request.port_is_range;
    case (request.command)
      CMD_ADD:    op_item.kind = rule_ok ? OP_ADD : OP_INVALID;
      CMD_DELETE: op_item.kind = rule_ok ? OP_DELETE : OP_INVALID;
      CMD_CHECK: begin
        op_item.kind = (request.addr_is_range || request.port_is_range) ?
                       OP_INVALID : OP_CHECK;
      end
      default:    op_item.kind = OP_INVALID;
    endcase
  end

endmodule

// ===== rtl/core/frtm_rule_table.sv =====
// ---------------------------------------------------------------------------
// frtm_rule_table
// Back end: a row of rule cells that compare in parallel, a registered
// first-hit reduction in groups, and insert/remove shifting of the cells.
// ---------------------------------------------------------------------------
module frtm_rule_table #(
  parameter int MAX_RULES = frtm_pkg::MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_empty,
  input  frtm_pkg::op_t       op_item,
  output logic                op_pop,
  output logic                res_push,
  output frtm_pkg::response_t res_item,
  input  logic                res_full,
  output logic [MAX_RULES-1:0] valid_map
);

  import frtm_pkg::*;

  localparam int NGROUP = (MAX_RULES + GRP_W - 1) / GRP_W;
  localparam int PADW   = NGROUP * GRP_W;
  localparam int GIW    = $clog2(GRP_W);
  localparam int GRPW   = (NGROUP > 1) ? $clog2(NGROUP) : 1;
  localparam int PW     = GRPW + GIW;

  bk_state_t        state;
  bk_state_t        state_next;
  op_t              cur;
  rule_t            cells [MAX_RULES];
  logic             entry_valid [MAX_RULES];
  logic [PADW-1:0]  cell_hit;
  logic [PADW-1:0]  match;
  logic [NGROUP-1:0] grp_any;
  logic [NGROUP-1:0] grp_any_next;
  logic [GIW-1:0]   grp_idx [NGROUP];
  logic [GIW-1:0]   grp_idx_next [NGROUP];
  logic             any_hit;
  logic [PW-1:0]    hit_pos;
  logic             do_add;
  logic             do_del;

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (!op_empty) state_next = BK_REDUCE;
      BK_REDUCE: state_next = BK_APPLY;
      BK_APPLY:  if (!res_full) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    op_pop   = 1'b0;
    res_push = 1'b0;
    case (state)
      BK_IDLE:  op_pop = !op_empty;
      BK_APPLY: res_push = !res_full;
      default: begin
        op_pop   = 1'b0;
        res_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-cell compare against the operation at the queue head
  for (genvar k = 0; k < MAX_RULES; k++) begin : g_cmp
    logic a_eq, p_eq, a_cov, p_cov, same;
    assign a_eq  = (cells[k].addr_lo == op_item.rule.addr_lo) &&
                   (cells[k].addr_rng == op_item.rule.addr_rng) &&
                   (!op_item.rule.addr_rng || (cells[k].addr_hi == op_item.rule.addr_hi));
    assign p_eq  = (cells[k].port_lo == op_item.rule.port_lo) &&
                   (cells[k].port_rng == op_item.rule.port_rng) &&
                   (!op_item.rule.port_rng || (cells[k].port_hi == op_item.rule.port_hi));
    assign a_cov = (op_item.rule.addr_lo == cells[k].addr_lo) ||
                   (cells[k].addr_rng && (op_item.rule.addr_lo > cells[k].addr_lo) &&
                    (op_item.rule.addr_lo <= cells[k].addr_hi));
    assign p_cov = (op_item.rule.port_lo == cells[k].port_lo) ||
                   (cells[k].port_rng && (op_item.rule.port_lo > cells[k].port_lo) &&
                    (op_item.rule.port_lo <= cells[k].port_hi));
    assign same  = (op_item.kind == OP_DELETE) ? (a_eq && p_eq) :
                   (op_item.kind == OP_CHECK)  ? (a_cov && p_cov) : 1'b0;
    assign cell_hit[k] = entry_valid[k] && same;
    assign valid_map[k] = entry_valid[k];
  end

  if (PADW > MAX_RULES) begin : g_pad
    assign cell_hit[PADW-1:MAX_RULES] = '0;
  end

  // Capture the operation and its hit vector
  always_ff @(posedge clk) begin
    if (op_pop) begin
      cur   <= op_item;
      match <= cell_hit;
    end
  end

  // First hit within each group
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_any_next[g] = |match[g*GRP_W +: GRP_W];
      grp_idx_next[g] = '0;
      for (int i = GRP_W - 1; i >= 0; i--) begin
        if (match[g*GRP_W + i]) grp_idx_next[g] = GIW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any <= grp_any_next;
    for (int g = 0; g < NGROUP; g++) begin
      grp_idx[g] <= grp_idx_next[g];
    end
  end

  // First group with a hit gives the position
  always_comb begin
    hit_pos = '0;
    for (int g = NGROUP - 1; g >= 0; g--) begin
      if (grp_any[g]) hit_pos = (PW'(g) << GIW) | PW'(grp_idx[g]);
    end
  end
  assign any_hit = |grp_any;

  assign do_add = res_push && (cur.kind == OP_ADD) && !entry_valid[MAX_RULES-1];
  assign do_del = res_push && (cur.kind == OP_DELETE) && any_hit;

  // Result
  always_comb begin
    res_item.status         = ST_INVALID;
    res_item.match_position = '0;
    case (cur.kind)
      OP_ADD: res_item.status = entry_valid[MAX_RULES-1] ? ST_FULL : ST_ADDED;
      OP_DELETE: begin
        res_item.status         = any_hit ? ST_DELETED : ST_NOT_FOUND;
        res_item.match_position = any_hit ? 6'(hit_pos) : '0;
      end
      OP_CHECK: begin
        res_item.status         = any_hit ? ST_ACCEPTED : ST_REJECTED;
        res_item.match_position = any_hit ? 6'(hit_pos) : '0;
      end
      default: res_item.status = ST_INVALID;
    endcase
  end

  // Cell row: shift down on add, close the gap on delete
  for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
    rule_t add_rule;
    logic  add_valid;
    rule_t del_rule;
    logic  del_valid;
    logic  shift_up;

    if (k == 0) begin : g_head
      assign add_rule  = cur.rule;
      assign add_valid = 1'b1;
    end else begin : g_body
      assign add_rule  = cells[k-1];
      assign add_valid = entry_valid[k-1];
    end

    if (k == MAX_RULES - 1) begin : g_tail
      assign del_rule  = cells[k];
      assign del_valid = 1'b0;
    end else begin : g_inner
      assign del_rule  = cells[k+1];
      assign del_valid = entry_valid[k+1];
    end

    assign shift_up = do_del && (PW'(k) >= hit_pos);

    always_ff @(posedge clk) begin
      if (do_add) begin
        cells[k] <= add_rule;
      end else if (shift_up) begin
        cells[k] <= del_rule;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        entry_valid[k] <= 1'b0;
      end else if (do_add) begin
        entry_valid[k] <= add_valid;
      end else if (shift_up) begin
        entry_valid[k] <= del_valid;
      end
    end
  end

endmodule

// ===== tb/rule_table_checker.sv =====
// ---------------------------------------------------------------------------
// rule_table_checker
// Watches both queues of the rule table core, keeps a shadow copy of the
// ordered rule table, predicts the verdict of every accepted command and
// compares each popped result with the oldest prediction.
// ---------------------------------------------------------------------------
module rule_table_checker #(
  parameter int MAX_RULES = frtm_pkg::MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  frtm_pkg::request_t  request,
  input  logic                empty,
  input  logic                pop,
  input  frtm_pkg::response_t response,
  output int                  fail_count,
  output int                  outstanding
);
  import frtm_pkg::*;

  // Shadow table: entries 0 .. rule_count-1 are valid, newest at 0
  rule_t     shadow_rules [MAX_RULES];
  int        rule_count = 0;
  response_t expected_verdicts [$];
  response_t oldest;
  int        fails = 0;
  int        waiting = 0;

  assign fail_count  = fails;
  assign outstanding = waiting;

  // Apply one command to the shadow table and return its verdict
  function automatic response_t predict_verdict(request_t rq);
    response_t v;
    rule_t     r;
    bit        well_formed;
    bit        addr_ok;
    bit        port_ok;
    int        hit;
    v.status         = ST_INVALID;
    v.match_position = '0;
    hit              = -1;
    well_formed = (!rq.addr_is_range || rq.addr_first < rq.addr_last) &&
                  (!rq.port_is_range || rq.port_first < rq.port_last);
    // high bounds of single values are stored as zero
    r.addr_lo  = rq.addr_first;
    r.addr_hi  = rq.addr_is_range ? rq.addr_last : '0;
    r.addr_rng = rq.addr_is_range;
    r.port_lo  = rq.port_first;
    r.port_hi  = rq.port_is_range ? rq.port_last : '0;
    r.port_rng = rq.port_is_range;
    case (rq.command)
      CMD_ADD: begin
        if (!well_formed) begin
          v.status = ST_INVALID;
        end else if (rule_count == MAX_RULES) begin
          v.status = ST_FULL;
        end else begin
          for (int k = rule_count; k > 0; k--) shadow_rules[k] = shadow_rules[k-1];
          shadow_rules[0] = r;
          rule_count++;
          v.status = ST_ADDED;
        end
      end
      CMD_DELETE: begin
        if (!well_formed) begin
          v.status = ST_INVALID;
        end else begin
          // zeroed high bounds make whole-rule equality the exact match
          for (int k = 0; k < rule_count && hit < 0; k++)
            if (shadow_rules[k] == r) hit = k;
          if (hit < 0) begin
            v.status = ST_NOT_FOUND;
          end else begin
            for (int k = hit; k < rule_count - 1; k++) shadow_rules[k] = shadow_rules[k+1];
            rule_count--;
            v.status         = ST_DELETED;
            v.match_position = hit[5:0];
          end
        end
      end
      CMD_CHECK: begin
        if (rq.addr_is_range || rq.port_is_range) begin
          v.status = ST_INVALID;
        end else begin
          v.status = ST_REJECTED;
          for (int k = 0; k < rule_count && hit < 0; k++) begin
            addr_ok = (rq.addr_first == shadow_rules[k].addr_lo) ||
                      (shadow_rules[k].addr_rng && rq.addr_first > shadow_rules[k].addr_lo &&
                       rq.addr_first <= shadow_rules[k].addr_hi);
            port_ok = (rq.port_first == shadow_rules[k].port_lo) ||
                      (shadow_rules[k].port_rng && rq.port_first > shadow_rules[k].port_lo &&
                       rq.port_first <= shadow_rules[k].port_hi);
            if (addr_ok && port_ok) hit = k;
          end
          if (hit >= 0) begin
            v.status         = ST_ACCEPTED;
            v.match_position = hit[5:0];
          end
        end
      end
      default: v.status = ST_INVALID;
    endcase
    return v;
  endfunction

  // Result side first: a command accepted at this edge cannot have a result yet
  always @(posedge clk) begin
    if (rst) begin
      expected_verdicts.delete();
      rule_count = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: status %0d, match_position %0d",
                 response.status, response.match_position);
          fails++;
        end else begin
          oldest = expected_verdicts.pop_front();
          if (response.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, response.status);
            fails++;
          end
          if (response.match_position !== oldest.match_position) begin
            $error("match_position: expected %0d, got %0d",
                   oldest.match_position, response.match_position);
            fails++;
          end
        end
      end
      if (push && !full) expected_verdicts.push_back(predict_verdict(request));
    end
    waiting = expected_verdicts.size();
  end

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Drives the rule table core with directed commands, then with phases of
// random traffic (table fills, deletes of known rules, checks near rule
// bounds, noise) under varying idle rates on both queues; the checker
// beside the core predicts and compares every result.
// ---------------------------------------------------------------------------
module tb;
  import frtm_pkg::*;

  localparam int         HALF_PERIOD  = 4;
  localparam int         RESET_CYCLES = 10;
  localparam int         LONG_HOLD    = 200;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         RUN_LIMIT    = 2_000_000;
  localparam int         FILL_ITEMS   = 70;
  localparam int         MIXED_ITEMS  = 430;
  localparam int         RULE_MEMORY  = 128;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

  logic      clk     = 1'b0;
  logic      rst     = 1'b1;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  request_t  request = '0;
  logic      full;
  logic      empty;
  response_t response;
  int        fail_count;
  int        outstanding;

  int        send_idle_pct = 11;
  int        recv_idle_pct = 54;
  bit        hold_go = 1'b0;
  request_t  added_rules [$];

  firewall_rule_table_match_core #(
    .MAX_RULES (MAX_RULES_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .empty    (empty),
    .pop      (pop),
    .response (response)
  );

  rule_table_checker #(
    .MAX_RULES (MAX_RULES_DEF)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .request     (request),
    .empty       (empty),
    .pop         (pop),
    .response    (response),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #HALF_PERIOD clk = ~clk;

  // Hard stop in case the core hangs
  initial begin
    #RUN_LIMIT;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random pops, plus one long hold-off to back the core up
  initial begin
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item from a falling edge until the core takes it
  task automatic send_item(request_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic request_t make_item(logic [1:0] cmd, logic [31:0] af, logic [31:0] al,
                                         logic ar, logic [15:0] pf, logic [15:0] pl,
                                         logic pr);
    request_t rq;
    rq.command       = cmd;
    rq.addr_first    = af;
    rq.addr_last     = al;
    rq.addr_is_range = ar;
    rq.port_first    = pf;
    rq.port_last     = pl;
    rq.port_is_range = pr;
    return rq;
  endfunction

  // Addresses and ports mostly from narrow windows so that rules overlap
  function automatic logic [31:0] pick_addr();
    if ($urandom_range(3) == 0) return $urandom();
    return 32'h0a00_0000 + $urandom_range(255);
  endfunction

  function automatic logic [15:0] pick_port();
    if ($urandom_range(3) == 0) return 16'($urandom());
    return 16'd80 + 16'($urandom_range(15));
  endfunction

  function automatic request_t random_rule(logic [1:0] cmd);
    request_t rq;
    rq.command       = cmd;
    rq.addr_first    = pick_addr();
    rq.addr_is_range = 1'($urandom_range(1));
    rq.addr_last     = rq.addr_is_range ? rq.addr_first + $urandom_range(1, 64) : $urandom();
    rq.port_first    = pick_port();
    rq.port_is_range = 1'($urandom_range(1));
    rq.port_last     = rq.port_is_range ? rq.port_first + 16'($urandom_range(1, 8))
                                        : 16'($urandom());
    // now and then a range that is empty or runs backwards
    if ($urandom_range(15) == 0) begin
      if ($urandom_range(1)) begin
        rq.addr_is_range = 1'b1;
        rq.addr_last     = rq.addr_first - $urandom_range(0, 2);
      end else begin
        rq.port_is_range = 1'b1;
        rq.port_last     = rq.port_first - 16'($urandom_range(0, 2));
      end
    end
    return rq;
  endfunction

  // Check aimed at a known rule: at its bounds, inside, or just outside
  function automatic request_t check_near(request_t r);
    request_t rq;
    logic [31:0] a_top;
    logic [15:0] p_top;
    a_top = r.addr_is_range ? r.addr_last : r.addr_first;
    p_top = r.port_is_range ? r.port_last : r.port_first;
    rq.command = CMD_CHECK;
    case ($urandom_range(4))
      0:       rq.addr_first = r.addr_first;
      1:       rq.addr_first = a_top;
      2:       rq.addr_first = $urandom_range(a_top, r.addr_first);
      3:       rq.addr_first = r.addr_first - 1;
      default: rq.addr_first = a_top + 1;
    endcase
    case ($urandom_range(4))
      0:       rq.port_first = r.port_first;
      1:       rq.port_first = p_top;
      2:       rq.port_first = 16'($urandom_range(p_top, r.port_first));
      3:       rq.port_first = r.port_first - 16'd1;
      default: rq.port_first = p_top + 16'd1;
    endcase
    rq.addr_is_range = ($urandom_range(19) == 0);
    rq.port_is_range = ($urandom_range(19) == 0);
    rq.addr_last     = $urandom();
    rq.port_last     = 16'($urandom());
    return rq;
  endfunction

  // Mixed traffic: adds, deletes (mostly of rules sent earlier), checks, noise
  function automatic request_t next_command();
    request_t rq;
    int       sel;
    int       idx;
    sel = $urandom_range(99);
    if (sel < 32) begin
      rq = random_rule(CMD_ADD);
      added_rules.push_back(rq);
      if (added_rules.size() > RULE_MEMORY) void'(added_rules.pop_front());
    end else if (sel < 58) begin
      if (added_rules.size() != 0 && $urandom_range(4) != 0) begin
        idx = $urandom_range(added_rules.size() - 1);
        rq  = added_rules[idx];
        added_rules.delete(idx);
        rq.command = CMD_DELETE;
        // unused bounds must not matter
        if (!rq.addr_is_range) rq.addr_last = $urandom();
        if (!rq.port_is_range) rq.port_last = 16'($urandom());
      end else begin
        rq = random_rule(CMD_DELETE);
      end
    end else if (sel < 93) begin
      if (added_rules.size() != 0 && $urandom_range(3) != 0)
        rq = check_near(added_rules[$urandom_range(added_rules.size() - 1)]);
      else
        rq = check_near(random_rule(CMD_CHECK));
    end else begin
      rq = {$urandom(), $urandom(), $urandom(), 4'($urandom())};
    end
    return rq;
  endfunction

  // Main stimulus
  initial begin
    request_t rq;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, malformed ranges, exact delete, bounds
    send_item(make_item(CMD_CHECK,  32'h0,        32'h0,        1'b0, 16'h0,    16'h0,    1'b0));
    send_item(make_item(CMD_ADD,    32'h0,        32'hffff_ffff, 1'b0, 16'h0,   16'hffff, 1'b0));
    send_item(make_item(CMD_ADD,    32'h0,        32'hffff_ffff, 1'b1, 16'h0,   16'hffff, 1'b1));
    send_item(make_item(CMD_ADD,    32'hffff_ffff, 32'h0,       1'b0, 16'hffff, 16'h0,    1'b0));
    send_item(make_item(CMD_ADD,    32'h5,        32'h5,        1'b1, 16'd80,   16'd90,   1'b1));
    send_item(make_item(CMD_ADD,    32'h5,        32'h9,        1'b1, 16'd100,  16'd99,   1'b1));
    send_item(make_item(CMD_CHECK,  32'hffff_ffff, 32'h0,       1'b0, 16'hffff, 16'h0,    1'b0));
    send_item(make_item(CMD_CHECK,  32'h8000_0000, 32'h0,       1'b0, 16'h1234, 16'h0,    1'b0));
    send_item(make_item(CMD_CHECK,  32'h0,        32'h0,        1'b0, 16'h0,    16'h0,    1'b0));
    send_item(make_item(CMD_CHECK,  32'h0,        32'h1,        1'b1, 16'h0,    16'h0,    1'b0));
    send_item(make_item(CMD_CHECK,  32'h0,        32'h0,        1'b0, 16'h0,    16'h1,    1'b1));
    send_item(make_item(CMD_UNKNOWN, 32'h0,       32'h0,        1'b0, 16'h0,    16'h0,    1'b0));
    send_item(make_item(CMD_DELETE, 32'h0,        32'hffff_fffe, 1'b1, 16'h0,   16'hffff, 1'b1));
    send_item(make_item(CMD_DELETE, 32'h0,        32'h0,        1'b0, 16'h0,    16'h1,    1'b1));
    send_item(make_item(CMD_DELETE, 32'h7,        32'h3,        1'b1, 16'h0,    16'h0,    1'b0));
    send_item(make_item(CMD_DELETE, 32'h0,        32'hffff_ffff, 1'b1, 16'h0,   16'hffff, 1'b1));
    send_item(make_item(CMD_CHECK,  32'h0,        32'h0,        1'b0, 16'h0,    16'h0,    1'b0));
    send_item(make_item(CMD_CHECK,  32'h1,        32'h0,        1'b0, 16'h0,    16'h0,    1'b0));
    send_item(make_item(CMD_DELETE, 32'h0,        32'h1234_5678, 1'b0, 16'h0,   16'h4321, 1'b0));
    send_item(make_item(CMD_DELETE, 32'hffff_ffff, 32'h0,       1'b0, 16'hffff, 16'h0,    1'b0));
    send_item(make_item(CMD_DELETE, 32'hffff_ffff, 32'h0,       1'b0, 16'hffff, 16'h0,    1'b0));
    send_item(make_item(CMD_ADD,    32'd10,       32'd20,       1'b1, 16'd5,    16'd6,    1'b1));
    send_item(make_item(CMD_CHECK,  32'd10,       32'h0,        1'b0, 16'd5,    16'h0,    1'b0));
    send_item(make_item(CMD_CHECK,  32'd20,       32'h0,        1'b0, 16'd6,    16'h0,    1'b0));
    send_item(make_item(CMD_CHECK,  32'd21,       32'h0,        1'b0, 16'd6,    16'h0,    1'b0));

    // Random phases: each fills the table, then runs mixed traffic
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 11;
          hold_go       = 1'b1;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (FILL_ITEMS) begin
        rq = random_rule(CMD_ADD);
        added_rules.push_back(rq);
        if (added_rules.size() > RULE_MEMORY) void'(added_rules.pop_front());
        send_item(rq);
      end
      repeat (MIXED_ITEMS) send_item(next_command());
    end

    // Drain and verdict
    push <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
